// ----- src/bezier_point_evaluator_top_assert.svh -----
// ----------------------------------------------------------------------------
// bezier point evaluator assertion macros
// concurrent checks in simulation, empty bodies in synthesis
// ----------------------------------------------------------------------------
`ifndef BEZIER_POINT_EVALUATOR_TOP_ASSERT_SVH
`define BEZIER_POINT_EVALUATOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// condition that holds at every clock edge out of reset
`define BPE_ASSERT_HOLDS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("bpe check failed: invariant");

// consequence in the same cycle
`define BPE_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bpe check failed: implication");

// consequence in the next cycle
`define BPE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bpe check failed: next cycle");

`else

`define BPE_ASSERT_HOLDS(label, clk, rst, expr)
`define BPE_ASSERT_IMPL(label, clk, rst, ante, cons)
`define BPE_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- src/bpe_pkg.sv -----
// ----------------------------------------------------------------------------
// bpe_pkg
// widths, word types and lerp arithmetic shared by the bezier evaluator
// ----------------------------------------------------------------------------
package bpe_pkg;

   // coordinate and parameter widths
   localparam int COORD_BITS    = 16;
   localparam int FRACTION_BITS = 16;
   localparam int STEP_BITS     = 16;

   // curve geometry
   localparam int NUM_AXES   = 2;
   localparam int NUM_POINTS = 4;
   localparam int AXIS_X     = 0;
   localparam int AXIS_Y     = 1;

   // divider has one stage per quotient bit
   localparam int DIV_STAGES = FRACTION_BITS + 1;

   // decoupling queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // product of a coordinate difference and the parameter
   localparam int PROD_BITS = COORD_BITS + FRACTION_BITS + 3;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic [STEP_BITS-1:0]         step_type;
   typedef logic [FRACTION_BITS:0]       ufrac_type;
   typedef logic signed [PROD_BITS-1:0]  prod_type;
   typedef logic [QPTR_BITS-1:0]         qptr_type;
   typedef logic [QCNT_BITS-1:0]         qcnt_type;

   // curve degree codes
   localparam logic OP_QUADRATIC = 1'b0;
   localparam logic OP_CUBIC     = 1'b1;

   localparam step_type  STEP_COUNT_RESET = step_type'(16);
   localparam ufrac_type U_ONE = ufrac_type'(ufrac_type'(1) << FRACTION_BITS);

   // control points of one word, indexed by axis then point
   typedef struct packed {
      logic                                              opcode;
      coord_type [NUM_AXES-1:0][NUM_POINTS-1:0]          pt;
   } cmd_type;

   // word handed from the front part to the back part
   typedef struct packed {
      cmd_type   cmd;
      logic      clamped;
      ufrac_type u;
   } entry_type;

   // (b - a) * u, exact
   function automatic prod_type lerp_product(coord_type a, coord_type b, ufrac_type u);
      logic signed [COORD_BITS:0] diff;
      diff = $signed({b[COORD_BITS-1], b}) - $signed({a[COORD_BITS-1], a});
      return diff * $signed({1'b0, u});
   endfunction

   // a + floor(p >> fraction), result always lies between the operands
   function automatic coord_type lerp_finish(coord_type a, prod_type p);
      prod_type q;
      q = p >>> FRACTION_BITS;
      return coord_type'(a + q[COORD_BITS-1:0]);
   endfunction

endpackage

// ----- src/bpe_front.sv -----
// ----------------------------------------------------------------------------
// bpe_front
// accepts words, saturates the step and forms the curve parameter
// through a restoring divider pipelined one quotient bit per stage
// ----------------------------------------------------------------------------
`include "bezier_point_evaluator_top_assert.svh"

module bpe_front
   import bpe_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  step_type  step_count,
   input  logic      in_valid,
   output logic      in_stall,
   input  cmd_type   in_cmd,
   input  step_type  in_step,
   input  logic      queue_full,
   output logic      push,
   output entry_type push_data
);

   localparam int LAST = DIV_STAGES - 1;

   logic [DIV_STAGES-1:0] valid_ff;
   cmd_type   cmd_ff   [DIV_STAGES];
   logic      clamp_ff [DIV_STAGES];
   step_type  rem_ff   [DIV_STAGES];
   ufrac_type quo_ff   [DIV_STAGES];
   step_type  rem_in   [DIV_STAGES];
   ufrac_type quo_in   [DIV_STAGES];

   logic     front_en;
   logic     clamp_in;
   step_type sat_step;
   logic     hit_end;

   // pipeline moves unless the last word cannot enter the queue
   assign front_en = !(valid_ff[LAST] && queue_full);
   assign in_stall = !front_en;
   assign push     = front_en && valid_ff[LAST];

   // saturation and top quotient bit (s can only reach step_count)
   assign clamp_in  = in_step > step_count;
   assign sat_step  = clamp_in ? step_count : in_step;
   assign hit_end   = (sat_step == step_count);
   assign rem_in[0] = hit_end ? '0 : sat_step;
   assign quo_in[0] = ufrac_type'(hit_end) << FRACTION_BITS;

   // one shift, compare and subtract per stage
   for (genvar k = 1; k < DIV_STAGES; k++) begin : g_div
      logic [STEP_BITS:0] trial;
      logic [STEP_BITS:0] diff;
      logic               ge;
      assign trial     = {rem_ff[k-1], 1'b0};
      assign diff      = trial - {1'b0, step_count};
      assign ge        = trial >= {1'b0, step_count};
      assign rem_in[k] = ge ? diff[STEP_BITS-1:0] : trial[STEP_BITS-1:0];
      assign quo_in[k] = quo_ff[k-1] | (ufrac_type'(ge) << (FRACTION_BITS - k));
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (front_en) begin
         valid_ff <= {valid_ff[DIV_STAGES-2:0], in_valid};
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (front_en) begin
         cmd_ff[0]   <= in_cmd;
         clamp_ff[0] <= clamp_in;
         rem_ff[0]   <= rem_in[0];
         quo_ff[0]   <= quo_in[0];
         for (int k = 1; k < DIV_STAGES; k++) begin
            cmd_ff[k]   <= cmd_ff[k-1];
            clamp_ff[k] <= clamp_ff[k-1];
            rem_ff[k]   <= rem_in[k];
            quo_ff[k]   <= quo_in[k];
         end
      end
   end

   // zero step count gives the first point
   assign push_data.cmd     = cmd_ff[LAST];
   assign push_data.clamped = clamp_ff[LAST];
   assign push_data.u       = (step_count == '0) ? '0 : quo_ff[LAST];

   `BPE_ASSERT_IMPL(a_front_u_range, clock, reset, valid_ff[LAST], push_data.u <= U_ONE)

endmodule

// ----- src/bpe_queue.sv -----
// ----------------------------------------------------------------------------
// bpe_queue
// short register queue between the divider and the interpolation pipeline
// ----------------------------------------------------------------------------
`include "bezier_point_evaluator_top_assert.svh"

module bpe_queue
   import bpe_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_data,
   output logic      full,
   input  logic      pop,
   output entry_type head,
   output logic      empty
);

   entry_type entry_ff [QUEUE_DEPTH];
   qptr_type  wr_ptr_ff, wr_ptr_in;
   qptr_type  rd_ptr_ff, rd_ptr_in;
   qcnt_type  count_ff, count_in;

   assign full  = (count_ff == qcnt_type'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == qptr_type'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == qptr_type'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   `BPE_ASSERT_HOLDS(a_queue_count_bound, clock, reset, count_ff <= qcnt_type'(QUEUE_DEPTH))
   `BPE_ASSERT_IMPL(a_queue_no_overflow, clock, reset, push, !full)
   `BPE_ASSERT_IMPL(a_queue_no_underflow, clock, reset, pop, !empty)
   `BPE_ASSERT_NEXT(a_queue_fill, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1)

endmodule

// ----- src/bpe_back.sv -----
// ----------------------------------------------------------------------------
// bpe_back
// de casteljau interpolation pipeline, each lerp split into a multiply
// stage and a shift and add stage, three levels for both axes
// ----------------------------------------------------------------------------
module bpe_back
   import bpe_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  entry_type head,
   input  logic      empty,
   output logic      pop,
   output logic      out_valid,
   input  logic      out_stall,
   output coord_type out_point_x,
   output coord_type out_point_y,
   output logic      out_clamped
);

   localparam int L1 = NUM_POINTS - 1;
   localparam int L2 = NUM_POINTS - 2;

   logic [5:0] valid_ff;
   logic       back_en;

   // control that travels with each word
   logic      cubic0_ff, cubic1_ff, cubic2_ff;
   logic      clamp0_ff, clamp1_ff, clamp2_ff, clamp3_ff, clamp4_ff, clamp5_ff;
   ufrac_type u0_ff, u1_ff, u2_ff, u3_ff;

   // datapath stages
   coord_type base0_ff [NUM_AXES][L1];
   prod_type  prod0_ff [NUM_AXES][L1];
   coord_type lvl1_ff  [NUM_AXES][L1];
   coord_type base2_ff [NUM_AXES][L2];
   prod_type  prod2_ff [NUM_AXES][L2];
   coord_type lvl2_ff  [NUM_AXES][L2];
   coord_type base4_ff [NUM_AXES];
   prod_type  prod4_ff [NUM_AXES];
   coord_type res_ff   [NUM_AXES];

   // whole pipeline holds while the result word is stalled
   assign back_en   = !(valid_ff[5] && out_stall);
   assign pop       = back_en && !empty;
   assign out_valid = valid_ff[5];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (back_en) begin
         valid_ff <= {valid_ff[4:0], !empty};
      end
   end

   // control shift
   always_ff @(posedge clock) begin
      if (back_en) begin
         cubic0_ff <= (head.cmd.opcode == OP_CUBIC);
         cubic1_ff <= cubic0_ff;
         cubic2_ff <= cubic1_ff;
         clamp0_ff <= head.clamped;
         clamp1_ff <= clamp0_ff;
         clamp2_ff <= clamp1_ff;
         clamp3_ff <= clamp2_ff;
         clamp4_ff <= clamp3_ff;
         clamp5_ff <= clamp4_ff;
         u0_ff     <= head.u;
         u1_ff     <= u0_ff;
         u2_ff     <= u1_ff;
         u3_ff     <= u2_ff;
      end
   end

   // first level: three lerps between neighbouring control points
   always_ff @(posedge clock) begin
      if (back_en) begin
         for (int ax = 0; ax < NUM_AXES; ax++) begin
            for (int i = 0; i < L1; i++) begin
               base0_ff[ax][i] <= head.cmd.pt[ax][i];
               prod0_ff[ax][i] <= lerp_product(head.cmd.pt[ax][i], head.cmd.pt[ax][i+1],
                                               head.u);
               lvl1_ff[ax][i]  <= lerp_finish(base0_ff[ax][i], prod0_ff[ax][i]);
            end
         end
      end
   end

   // second level: cubic only, a quadratic word passes its two points on
   always_ff @(posedge clock) begin
      if (back_en) begin
         for (int ax = 0; ax < NUM_AXES; ax++) begin
            for (int j = 0; j < L2; j++) begin
               base2_ff[ax][j] <= lvl1_ff[ax][j];
               prod2_ff[ax][j] <= lerp_product(lvl1_ff[ax][j], lvl1_ff[ax][j+1], u1_ff);
               lvl2_ff[ax][j]  <= cubic2_ff ? lerp_finish(base2_ff[ax][j], prod2_ff[ax][j])
                                            : base2_ff[ax][j];
            end
         end
      end
   end

   // final level into the result register
   always_ff @(posedge clock) begin
      if (back_en) begin
         for (int ax = 0; ax < NUM_AXES; ax++) begin
            base4_ff[ax] <= lvl2_ff[ax][0];
            prod4_ff[ax] <= lerp_product(lvl2_ff[ax][0], lvl2_ff[ax][1], u3_ff);
            res_ff[ax]   <= lerp_finish(base4_ff[ax], prod4_ff[ax]);
         end
      end
   end

   assign out_point_x = res_ff[AXIS_X];
   assign out_point_y = res_ff[AXIS_Y];
   assign out_clamped = clamp5_ff;

endmodule

// ----- src/bezier_point_evaluator_top.sv -----
// ----------------------------------------------------------------------------
// bezier_point_evaluator_top
// one point of a quadratic or cubic 2d bezier curve per word
// ----------------------------------------------------------------------------
//  channel  direction  handshake           payload
//  req      in         req_valid/req_stall opcode, p0..p3 x/y, step
//  rsp      out        rsp_valid/rsp_stall point_x, point_y, step_clamped
//  csr      in         csr_valid/csr_ready step_count
//
// one word per cycle sustained while rsp_stall is low; an accepted word passes
// the 17 stage parameter divider, the queue and 6 lerp stages.
// reset is synchronous; step_count returns to 16, all pipelines empty.
// a stalled result holds only the lerp pipeline; the divider keeps
// accepting until the 4 word queue fills, then req_stall rises.
// csr_ready is always high.
// ----------------------------------------------------------------------------
module bezier_point_evaluator_top
   import bpe_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_stall,
   input  logic      req_opcode,
   input  coord_type req_p0_x,
   input  coord_type req_p0_y,
   input  coord_type req_p1_x,
   input  coord_type req_p1_y,
   input  coord_type req_p2_x,
   input  coord_type req_p2_y,
   input  coord_type req_p3_x,
   input  coord_type req_p3_y,
   input  step_type  req_step,
   output logic      rsp_valid,
   input  logic      rsp_stall,
   output coord_type rsp_point_x,
   output coord_type rsp_point_y,
   output logic      rsp_step_clamped,
   input  logic      csr_valid,
   output logic      csr_ready,
   input  step_type  csr_step_count
);

   step_type  step_count_ff;
   cmd_type   req_cmd;
   logic      queue_full;
   logic      queue_empty;
   logic      push;
   logic      pop;
   entry_type push_data;
   entry_type head;

   // step count register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_count_ff <= STEP_COUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         step_count_ff <= csr_step_count;
      end
   end

   // gather the incoming control points
   always_comb begin
      req_cmd.opcode        = req_opcode;
      req_cmd.pt[AXIS_X][0] = req_p0_x;
      req_cmd.pt[AXIS_Y][0] = req_p0_y;
      req_cmd.pt[AXIS_X][1] = req_p1_x;
      req_cmd.pt[AXIS_Y][1] = req_p1_y;
      req_cmd.pt[AXIS_X][2] = req_p2_x;
      req_cmd.pt[AXIS_Y][2] = req_p2_y;
      req_cmd.pt[AXIS_X][3] = req_p3_x;
      req_cmd.pt[AXIS_Y][3] = req_p3_y;
   end

   bpe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .step_count (step_count_ff),
      .in_valid   (req_valid),
      .in_stall   (req_stall),
      .in_cmd     (req_cmd),
      .in_step    (req_step),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   bpe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .head      (head),
      .empty     (queue_empty)
   );

   bpe_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .empty       (queue_empty),
      .pop         (pop),
      .out_valid   (rsp_valid),
      .out_stall   (rsp_stall),
      .out_point_x (rsp_point_x),
      .out_point_y (rsp_point_y),
      .out_clamped (rsp_step_clamped)
   );

endmodule
